>>> hw/rtl/tpq_pkg.sv
// ---------------------------------------------------------------------------
// tpq_pkg: shared types and constants of the timeout priority queue
// Field widths, result and command codes, register indexes, slot layout.
// ---------------------------------------------------------------------------
package tpq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int DL_W       = 64;
	localparam int TAG_W      = 32;
	localparam int KIND_W     = 2;
	localparam int PERIOD_W   = 16;
	localparam int IN_TDATA_W = 96;
	localparam int OUT_TDATA_W = 168;
	localparam int REG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// input command (tuser)
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_ADD  = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FULL    = 2'd3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_TASK_PERIOD = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_TASK_TAG    = 1'd1;

	localparam logic [PERIOD_W-1:0]     PERIOD_RST = 16'd2;
	localparam logic signed [TAG_W-1:0] TAG_RST    = 32'sh8000_0000;

	typedef struct packed {
		logic                    due;
		logic signed [TAG_W-1:0] tag;
		logic [DL_W-1:0]         deadline;
	} slot_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [DL_W-1:0]         dl;
		logic signed [TAG_W-1:0] tag;
		logic                    sw;
		logic [DL_W-1:0]         now;
		logic                    last;
	} res_t;

endpackage

>>> hw/rtl/tpq_slot_mem.sv
// ---------------------------------------------------------------------------
// tpq_slot_mem: timer slot storage
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tpq_slot_mem #(
	parameter int DEPTH = tpq_pkg::CAPACITY_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  tpq_pkg::slot_t       wdata,
	input  logic [IDX_W-1:0]     raddr,
	output tpq_pkg::slot_t       rdata
);

	tpq_pkg::slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/tpq_cmp.sv
// ---------------------------------------------------------------------------
// tpq_cmp: shared 64-bit magnitude comparator
// Unsigned a < b from the borrow of a 65-bit subtract.
// ---------------------------------------------------------------------------
module tpq_cmp (
	input  logic [tpq_pkg::DL_W-1:0] a,
	input  logic [tpq_pkg::DL_W-1:0] b,
	output logic                     lt
);

	logic [tpq_pkg::DL_W:0] diff;

	assign diff = {1'b0, a} - {1'b0, b};
	assign lt   = diff[tpq_pkg::DL_W];

endmodule

>>> hw/rtl/tpq_ctrl.sv
// ---------------------------------------------------------------------------
// tpq_ctrl: timer queue sequencer
// Slots are kept packed in insertion order. A tick marks due slots, then
// repeatedly scans for the earliest due slot, closes the gap and either
// re-arms it (task timer) or reports it.
// ---------------------------------------------------------------------------
module tpq_ctrl #(
	parameter int CAPACITY = tpq_pkg::CAPACITY_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  in_func,
	input  logic [tpq_pkg::DL_W-1:0]              in_deadline,
	input  logic signed [tpq_pkg::TAG_W-1:0]      in_tag,
	input  logic [tpq_pkg::PERIOD_W-1:0]          task_period,
	input  logic signed [tpq_pkg::TAG_W-1:0]      task_tag,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output tpq_pkg::res_t                         res
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DUE   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_REARM = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]                       state_q, ret_q;
	logic [CNT_W-1:0]                 n_q, raddr_q, idx_s1, best_idx_q, idx_dec;
	logic                             v_s1, found_q, sw_q;
	logic [tpq_pkg::DL_W-1:0]         count_q, best_dl_q, rearm_dl;
	logic signed [tpq_pkg::TAG_W-1:0] best_tag_q;
	logic [tpq_pkg::DL_W:0]           rearm_sum;
	tpq_pkg::res_t                    res_q;

	logic                             mem_we;
	logic [IDX_W-1:0]                 mem_waddr;
	tpq_pkg::slot_t                   mem_wdata, mem_rdata;

	logic [tpq_pkg::DL_W-1:0]         cmp_a, cmp_b;
	logic                             cmp_lt;

	logic                             read_go, pass_end, scan_take, in_acc, is_full;

	tpq_slot_mem #(.DEPTH(CAPACITY), .IDX_W(IDX_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (raddr_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	// due pass: count < deadline means not due; scan: candidate earlier than best
	always_comb begin
		if (state_q == ST_DUE) begin
			cmp_a = count_q;
			cmp_b = mem_rdata.deadline;
		end else begin
			cmp_a = mem_rdata.deadline;
			cmp_b = best_dl_q;
		end
	end

	tpq_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign is_full   = (n_q == CNT_MAX);
	assign read_go   = (raddr_q != n_q);
	assign pass_end  = !read_go && !v_s1;
	assign scan_take = mem_rdata.due && (!found_q || cmp_lt);
	assign idx_dec   = idx_s1 - CNT_W'(1);

	// re-arm deadline saturates at all ones
	assign rearm_sum = {1'b0, count_q} + (tpq_pkg::DL_W + 1)'(task_period);
	assign rearm_dl  = rearm_sum[tpq_pkg::DL_W] ? '1 : rearm_sum[tpq_pkg::DL_W-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = n_q[IDX_W-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_func == tpq_pkg::FUNC_ADD && !is_full) begin
					mem_we             = 1'b1;
					mem_wdata.due      = 1'b0;
					mem_wdata.tag      = in_tag;
					mem_wdata.deadline = in_deadline;
				end
			end
			ST_DUE: begin
				if (v_s1) begin
					mem_we        = 1'b1;
					mem_waddr     = idx_s1[IDX_W-1:0];
					mem_wdata.due = !cmp_lt;
				end
			end
			ST_SHIFT: begin
				if (v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_dec[IDX_W-1:0];
				end
			end
			ST_REARM: begin
				mem_we             = 1'b1;
				mem_wdata.due      = 1'b0;
				mem_wdata.tag      = best_tag_q;
				mem_wdata.deadline = rearm_dl;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			n_q     <= '0;
			raddr_q <= '0;
			v_s1    <= 1'b0;
			found_q <= 1'b0;
			sw_q    <= 1'b0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_func == tpq_pkg::FUNC_ADD) begin
							if (!is_full) begin
								n_q <= n_q + CNT_W'(1);
							end
							state_q <= ST_EMIT;
							ret_q   <= ST_IDLE;
						end else begin
							count_q <= count_q + 64'd1;
							sw_q    <= 1'b0;
							raddr_q <= '0;
							v_s1    <= 1'b0;
							state_q <= ST_DUE;
						end
					end
				end
				ST_DUE, ST_SCAN, ST_SHIFT: begin
					v_s1 <= read_go;
					if (read_go) begin
						raddr_q <= raddr_q + CNT_W'(1);
					end
					if (state_q == ST_SCAN && v_s1 && scan_take) begin
						found_q <= 1'b1;
					end
					if (pass_end) begin
						if (state_q == ST_DUE) begin
							state_q <= ST_SCAN;
							raddr_q <= '0;
							found_q <= 1'b0;
						end else if (state_q == ST_SCAN) begin
							if (found_q) begin
								state_q <= ST_SHIFT;
								raddr_q <= best_idx_q + CNT_W'(1);
							end else begin
								state_q <= ST_EMIT;
								ret_q   <= ST_IDLE;
							end
						end else begin
							n_q     <= n_q - CNT_W'(1);
							ret_q   <= ST_SCAN;
							state_q <= (best_tag_q == task_tag) ? ST_REARM : ST_EMIT;
						end
					end
				end
				ST_REARM: begin
					n_q     <= n_q + CNT_W'(1);
					sw_q    <= 1'b1;
					raddr_q <= '0;
					found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ret_q;
						raddr_q <= '0;
						found_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		idx_s1 <= raddr_q;
		if (state_q == ST_SCAN && v_s1 && scan_take) begin
			best_idx_q <= idx_s1;
			best_dl_q  <= mem_rdata.deadline;
			best_tag_q <= mem_rdata.tag;
		end
		if (in_acc && in_func == tpq_pkg::FUNC_ADD) begin
			res_q.kind <= is_full ? tpq_pkg::KIND_FULL : tpq_pkg::KIND_ADDED;
			res_q.dl   <= '0;
			res_q.tag  <= '0;
			res_q.sw   <= 1'b0;
			res_q.now  <= count_q;
			res_q.last <= 1'b1;
		end
		if (state_q == ST_SCAN && pass_end && !found_q) begin
			res_q.kind <= tpq_pkg::KIND_DONE;
			res_q.dl   <= '0;
			res_q.tag  <= '0;
			res_q.sw   <= sw_q;
			res_q.now  <= count_q;
			res_q.last <= 1'b1;
		end
		if (state_q == ST_SHIFT && pass_end) begin
			res_q.kind <= tpq_pkg::KIND_EXPIRED;
			res_q.dl   <= best_dl_q;
			res_q.tag  <= best_tag_q;
			res_q.sw   <= 1'b0;
			res_q.now  <= count_q;
			res_q.last <= 1'b0;
		end
	end

	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_MAX)
		else $error("slot fill count beyond capacity");

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_func == tpq_pkg::FUNC_TICK) |=> count_q == $past(count_q) + 64'd1)
		else $error("tick count did not advance");

	a_add_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_func == tpq_pkg::FUNC_ADD && !is_full) |=> n_q == $past(n_q) + CNT_W'(1))
		else $error("add did not grow the store");

	a_shift_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> found_q)
		else $error("removal without a selected slot");

endmodule

>>> hw/rtl/timeout_priority_queue.sv
// ---------------------------------------------------------------------------
// timeout_priority_queue: tick counter with a bounded list of pending timers
// Add transactions store timers; tick transactions report expired timers.
// ---------------------------------------------------------------------------
// One sequencer walks a slot memory (one write port, one registered read port)
// with one shared comparator, one slot per cycle, and the block takes no new
// transaction until the current one is finished. An add takes the accept
// step and the output handoff. A tick takes the accept step, a due-marking
// pass, then for each expired timer one scan, a gap-closing pass and a
// re-arm or report step, then a final scan and the tick-done handoff; each
// report and handoff waits while the output side stalls. Expired timers come
// out earliest deadline first, equal deadlines in insertion order, and every
// tick ends with a tick-done result carrying task_switch.
module timeout_priority_queue #(
	parameter int CAPACITY = tpq_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [tpq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // deadline[63:0], tag[95:64]
	input  logic                                s_axis_tuser,  // func
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// expired_deadline[63:0], expired_tag[95:64], task_switch[96], now[160:97], zero pad
	output logic [tpq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic [tpq_pkg::KIND_W-1:0]          m_axis_tuser,  // kind
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  logic [tpq_pkg::REG_IDX_W-1:0]       cfg_addr,
	input  logic [tpq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int PAD_W = tpq_pkg::OUT_TDATA_W - 2 * tpq_pkg::DL_W - tpq_pkg::TAG_W - 1;

	logic [tpq_pkg::PERIOD_W-1:0]     task_period_q;
	logic signed [tpq_pkg::TAG_W-1:0] task_tag_q;
	logic                             res_valid, res_ready, out_valid_q;
	tpq_pkg::res_t                    res, out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_period_q <= tpq_pkg::PERIOD_RST;
			task_tag_q    <= tpq_pkg::TAG_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				tpq_pkg::REG_TASK_PERIOD: task_period_q <= cfg_wdata[tpq_pkg::PERIOD_W-1:0];
				tpq_pkg::REG_TASK_TAG:    task_tag_q    <= cfg_wdata[tpq_pkg::TAG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_func     (s_axis_tuser),
		.in_deadline (s_axis_tdata[tpq_pkg::DL_W-1:0]),
		.in_tag      (s_axis_tdata[tpq_pkg::DL_W +: tpq_pkg::TAG_W]),
		.task_period (task_period_q),
		.task_tag    (task_tag_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// output register: next result loads as the current one leaves
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q.now, out_q.sw, out_q.tag, out_q.dl};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule

>>> sim/tb_timeout_priority_queue.sv
// ---------------------------------------------------------------------------
// tb_timeout_priority_queue: self-checking bench for the timeout priority queue
// Drives add and tick transactions with random gaps on both stream sides,
// predicts every result from a local model of the timer store and compares
// each output transaction field by field, in order.
// ---------------------------------------------------------------------------
module tb_timeout_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP          = tpq_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 1000;

	logic                                clk            = 1'b0;
	logic                                arst_n         = 1'b0;
	logic                                s_axis_tvalid  = 1'b0;
	logic                                s_axis_tready;
	logic [tpq_pkg::IN_TDATA_W-1:0]      s_axis_tdata   = '0;
	logic                                s_axis_tuser   = tpq_pkg::FUNC_TICK;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready  = 1'b0;
	logic [tpq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
	logic [tpq_pkg::KIND_W-1:0]          m_axis_tuser;
	logic                                m_axis_tlast;
	logic                                cfg_we         = 1'b0;
	logic [tpq_pkg::REG_IDX_W-1:0]       cfg_addr       = tpq_pkg::REG_TASK_PERIOD;
	logic [tpq_pkg::CFG_DATA_W-1:0]      cfg_wdata      = '0;

	// local copy of the timer store, oldest first
	logic [tpq_pkg::DL_W-1:0]            tick_now     = '0;
	logic [tpq_pkg::DL_W-1:0]            timer_dl[$];
	logic signed [tpq_pkg::TAG_W-1:0]    timer_tag[$];
	bit                                  timer_due[$];
	logic [tpq_pkg::PERIOD_W-1:0]        cur_period   = tpq_pkg::PERIOD_RST;
	logic signed [tpq_pkg::TAG_W-1:0]    cur_task_tag = tpq_pkg::TAG_RST;
	tpq_pkg::res_t                       report_q[$];

	int unsigned fail_cnt  = 0;
	int unsigned cycle_cnt = 0;
	bit          no_idle   = 1'b0;
	bit          hold_req  = 1'b0;
	int          hold_left = 0;
	int          rdy_gap   = 0;

	timeout_priority_queue u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly zero, sometimes short, rarely long
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic tpq_pkg::res_t mk_report(logic [tpq_pkg::KIND_W-1:0] k,
			logic [tpq_pkg::DL_W-1:0] d, logic signed [tpq_pkg::TAG_W-1:0] t,
			logic s, logic l);
		tpq_pkg::res_t r;
		r.kind = k;
		r.dl   = d;
		r.tag  = t;
		r.sw   = s;
		r.now  = tick_now;
		r.last = l;
		return r;
	endfunction

	function automatic void predict_reports(logic func, logic [tpq_pkg::DL_W-1:0] dl,
			logic signed [tpq_pkg::TAG_W-1:0] tg);
		int                               best;
		logic [tpq_pkg::DL_W-1:0]         bdl;
		logic signed [tpq_pkg::TAG_W-1:0] btg;
		logic [tpq_pkg::DL_W:0]           rearm;
		logic                             switched;
		switched = 1'b0;
		if (func == tpq_pkg::FUNC_ADD) begin
			if (timer_dl.size() >= CAP) begin
				report_q.push_back(mk_report(tpq_pkg::KIND_FULL, '0, '0, 1'b0, 1'b1));
			end else begin
				timer_dl.push_back(dl);
				timer_tag.push_back(tg);
				timer_due.push_back(1'b0);
				report_q.push_back(mk_report(tpq_pkg::KIND_ADDED, '0, '0, 1'b0, 1'b1));
			end
		end else begin
			tick_now = tick_now + 64'd1;
			foreach (timer_dl[i])
				timer_due[i] = (timer_dl[i] <= tick_now);
			best = 0;
			while (best >= 0) begin
				best = -1;
				// strict compare keeps the oldest of equal deadlines
				foreach (timer_dl[i])
					if (timer_due[i] && (best < 0 || timer_dl[i] < timer_dl[best]))
						best = i;
				if (best >= 0) begin
					bdl = timer_dl[best];
					btg = timer_tag[best];
					timer_dl.delete(best);
					timer_tag.delete(best);
					timer_due.delete(best);
					if (btg == cur_task_tag) begin
						// re-armed timer goes to the back, not due this tick
						rearm = {1'b0, tick_now} + (tpq_pkg::DL_W + 1)'(cur_period);
						timer_dl.push_back(rearm[tpq_pkg::DL_W] ? {tpq_pkg::DL_W{1'b1}} :
							rearm[tpq_pkg::DL_W-1:0]);
						timer_tag.push_back(btg);
						timer_due.push_back(1'b0);
						switched = 1'b1;
					end else begin
						report_q.push_back(mk_report(tpq_pkg::KIND_EXPIRED, bdl, btg,
							1'b0, 1'b0));
					end
				end
			end
			report_q.push_back(mk_report(tpq_pkg::KIND_DONE, '0, '0, switched, 1'b1));
		end
	endfunction

	task automatic send_item(input logic func, input logic [tpq_pkg::DL_W-1:0] dl,
			input logic signed [tpq_pkg::TAG_W-1:0] tg);
		int gap;
		gap = no_idle ? 0 : rand_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {tg, dl};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_reports(func, dl, tg);
	endtask

	// only while nothing is in flight
	task automatic write_reg(input logic [tpq_pkg::REG_IDX_W-1:0] idx,
			input logic [tpq_pkg::CFG_DATA_W-1:0] data);
		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tpq_pkg::REG_TASK_PERIOD)
			cur_period = data[tpq_pkg::PERIOD_W-1:0];
		else
			cur_task_tag = data;
		@(posedge clk);
	endtask

	task automatic send_random_item(input int task_pct);
		logic [tpq_pkg::DL_W-1:0]         dl;
		logic signed [tpq_pkg::TAG_W-1:0] tg;
		int                               ntask;
		int                               r;
		ntask = 0;
		foreach (timer_tag[i])
			if (timer_tag[i] == cur_task_tag)
				ntask++;
		r = $urandom_range(0, 99);
		if ((r < 45 && timer_dl.size() < CAP) || r < 3) begin
			if ($urandom_range(0, 9) == 0)
				dl = (tick_now >= 64'd5) ? tick_now - 64'($urandom_range(0, 5)) : '0;
			else
				dl = tick_now + 64'($urandom_range(0, 10));
			tg = $urandom;
			if (ntask < 2 && $urandom_range(0, 99) < task_pct)
				tg = cur_task_tag;
			send_item(tpq_pkg::FUNC_ADD, dl, tg);
		end else begin
			// tick ignores the data, drive junk anyway
			send_item(tpq_pkg::FUNC_TICK, {$urandom, $urandom}, $urandom);
		end
	endtask

	// past deadline, earliest first, tag extremes
	task automatic test_basic_expiry;
		send_item(tpq_pkg::FUNC_ADD, 64'd0, 32'sh7FFF_FFFF);
		send_item(tpq_pkg::FUNC_ADD, 64'd2, -32'sd1);
		send_item(tpq_pkg::FUNC_ADD, 64'd1, 32'sd0);
		send_item(tpq_pkg::FUNC_TICK, '0, '0);
		send_item(tpq_pkg::FUNC_TICK, {tpq_pkg::DL_W{1'b1}}, 32'sh8000_0000);
	endtask

	task automatic test_task_switch;
		send_item(tpq_pkg::FUNC_ADD, tick_now + 64'd1, tpq_pkg::TAG_RST);
		send_item(tpq_pkg::FUNC_TICK, '0, '0);
		write_reg(tpq_pkg::REG_TASK_PERIOD, '0);
		send_item(tpq_pkg::FUNC_TICK, '0, '0);
		send_item(tpq_pkg::FUNC_TICK, '0, '0);
		// old task timer turns into a plain one and gets reported
		write_reg(tpq_pkg::REG_TASK_TAG, 32'h7FFF_FFFF);
		send_item(tpq_pkg::FUNC_TICK, '0, '0);
	endtask

	// fill with equal deadlines, overflow once, then drain all in one tick
	task automatic test_full_store;
		logic [tpq_pkg::DL_W-1:0] dl;
		no_idle = 1'b1;
		dl = tick_now + 64'd1;
		while (timer_dl.size() < CAP)
			send_item(tpq_pkg::FUNC_ADD, dl, $urandom);
		send_item(tpq_pkg::FUNC_ADD, dl, 32'sd0);
		send_item(tpq_pkg::FUNC_TICK, '0, '0);
		no_idle = 1'b0;
	endtask

	task automatic test_random_traffic;
		logic [tpq_pkg::PERIOD_W-1:0]     per;
		logic signed [tpq_pkg::TAG_W-1:0] tt;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: per = 16'd1;
				5: per = 16'hFFFF;
				default: per = $urandom_range(1, 6);
			endcase
			case (ph)
				1: tt = 32'sh7FFF_FFFF;
				2: tt = 32'sh8000_0000;
				default: tt = $urandom;
			endcase
			write_reg(tpq_pkg::REG_TASK_PERIOD, {16'h0, per});
			write_reg(tpq_pkg::REG_TASK_TAG, tt);
			no_idle = (ph == 4);
			repeat (20)
				send_random_item(ph == 5 ? 5 : 20);
		end
		no_idle = 1'b0;
	endtask

	// output side holds off while input keeps offering
	task automatic test_backpressure;
		hold_req = 1'b1;
		no_idle  = 1'b1;
		repeat (20)
			send_random_item(20);
		no_idle = 1'b0;
	endtask

	// deadlines that never come fill the store for good
	task automatic test_stuck_timers;
		while (timer_dl.size() < CAP)
			send_item(tpq_pkg::FUNC_ADD, {tpq_pkg::DL_W{1'b1}}, $urandom);
		send_item(tpq_pkg::FUNC_ADD, {tpq_pkg::DL_W{1'b1}}, -32'sd1);
		send_item(tpq_pkg::FUNC_TICK, '0, '0);
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rdy_gap > 0) begin
			rdy_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0)
				rdy_gap = rand_gap();
		end
	end

	function automatic void check_field(string fname, logic [tpq_pkg::DL_W-1:0] want,
			logic [tpq_pkg::DL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		tpq_pkg::res_t got;
		tpq_pkg::res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.dl   = m_axis_tdata[63:0];
			got.tag  = m_axis_tdata[95:64];
			got.sw   = m_axis_tdata[96];
			got.now  = m_axis_tdata[160:97];
			got.last = m_axis_tlast;
			if (report_q.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got kind %0d now %0h",
					$time, got.kind, got.now);
				fail_cnt++;
			end else begin
				want = report_q.pop_front();
				check_field("kind", 64'(want.kind), 64'(got.kind));
				check_field("expired_deadline", want.dl, got.dl);
				check_field("expired_tag", 64'(want.tag), 64'(got.tag));
				check_field("task_switch", 64'(want.sw), 64'(got.sw));
				check_field("now", want.now, got.now);
				check_field("last", 64'(want.last), 64'(got.last));
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_timeout_priority_queue NOT OK");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_expiry();
		test_task_switch();
		test_full_store();
		test_random_traffic();
		test_backpressure();
		test_stuck_timers();
		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb_timeout_priority_queue OK");
		else
			$display("tb_timeout_priority_queue NOT OK");
		$finish;
	end

endmodule
